// ===== design/hlbs_pkg.sv =====
// Package for the haptic limit bounce spring core.
// Holds payload structs, register index and mode codes, and fixed-point constants.
// No dependencies.
package hlbs_pkg;

  localparam int ANGLE_W    = 24;
  localparam int VEL_W      = 16;
  localparam int GAIN_W     = 16;
  localparam int LEVEL_W    = 7;
  localparam int TICK_W     = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Error is the difference of two angles, so it needs one more bit.
  localparam int ERR_W   = ANGLE_W + 1;
  localparam int AVEL_W  = VEL_W + 1;
  localparam int PERR_W  = ERR_W + GAIN_W;
  localparam int PVEL_W  = AVEL_W + GAIN_W;
  localparam int FORCE_W = PERR_W + 1;
  localparam int FRAC_W  = 16;

  localparam int SETTLE_TICKS  = 50;
  localparam int TICK_MAX      = (1 << TICK_W) - 1;
  localparam int LEVEL_FLOOR   = 20;
  localparam int SETTLE_ERR_Q8 = 768;
  // |vel| * 10 < 768 holds exactly when |vel| is below the rounded-up quotient.
  localparam int SETTLE_VEL_LIM = (768 + 9) / 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIMIT_MODE,
    CFG_UPPER_LIMIT,
    CFG_LOWER_LIMIT,
    CFG_SPRING_GAIN,
    CFG_DAMPING_GAIN,
    CFG_MAX_LEVEL
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_OFF,
    MODE_UPPER,
    MODE_BOTH
  } limit_mode_e;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] knob_angle;
    logic signed [VEL_W-1:0]   knob_velocity;
  } in_item_t;

  typedef struct packed {
    logic               engaged;
    logic               drive_reverse;
    logic [LEVEL_W-1:0] drive_level;
  } out_item_t;

endpackage

// ===== design/haptic_limit_bounce_spring_core.sv =====
// Haptic limit bounce spring core: a virtual end stop for a haptic knob.
// Items pass s0, s1, s2 and the out register; one item per cycle is sustained unless stalled.
// The bounce state (bounce flag, anchor, settle count) is updated in the first stage, so
// the next item already sees it. Reset is asynchronous and active low:
// it clears the pipeline, the bounce flag and settle count, and sets the registers to
// their defaults (max_level 100). Depends on hlbs_pkg.
module haptic_limit_bounce_spring_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  hlbs_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output hlbs_pkg::out_item_t             out_item_o,
  input  logic                            cfg_we_i,
  input  logic [hlbs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hlbs_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import hlbs_pkg::*;

  // Configuration registers.
  logic [1:0]                mode_q;
  logic signed [ANGLE_W-1:0] upper_q;
  logic signed [ANGLE_W-1:0] lower_q;
  logic [GAIN_W-1:0]         spring_q;
  logic [GAIN_W-1:0]         damping_q;
  logic [LEVEL_W-1:0]        max_q;
  logic                      cfg_hit;

  // Bounce state.
  logic                      bounce_q, bounce_d;
  logic signed [ANGLE_W-1:0] anchor_q, anchor_d;
  logic [TICK_W-1:0]         ticks_q, ticks_d;

  // Pipeline: s0 holds the accepted item, s1 the error magnitudes, s2 the
  // products, and the output register the finished result.
  logic              s0_v_q, s1_v_q, s2_v_q, out_v_q;
  logic              s0_rdy, s1_rdy, s2_rdy, out_rdy;
  logic              s0_fire, s1_fire, s2_fire;
  in_item_t          s0_item_q;

  logic              s1_eng_q, s1_rev_q;
  logic [ERR_W-1:0]  s1_aerr_q;
  logic [AVEL_W-1:0] s1_avel_q;

  logic              s2_eng_q, s2_rev_q;
  logic [PERR_W-1:0] s2_perr_q;
  logic [PVEL_W-1:0] s2_pvel_q;

  out_item_t         out_item_q, out_item_d;

  // Ready chain: a stage takes a new item when it is empty or its item moves on.
  assign out_rdy = !out_v_q || !out_stall_i;
  assign s2_rdy  = !s2_v_q || out_rdy;
  assign s1_rdy  = !s1_v_q || s2_rdy;
  assign s0_rdy  = !s0_v_q || s1_rdy;
  assign s0_fire = s0_v_q && s1_rdy;
  assign s1_fire = s1_v_q && s2_rdy;
  assign s2_fire = s2_v_q && out_rdy;

  assign in_stall_o  = !s0_rdy;
  assign out_valid_o = out_v_q;
  assign out_item_o  = out_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s0_rdy) begin
        s0_v_q <= in_valid_i;
      end
      if (s1_rdy) begin
        s1_v_q <= s0_v_q;
      end
      if (s2_rdy) begin
        s2_v_q <= s1_v_q;
      end
      if (out_rdy) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  // Configuration writes. Any listed index also clears bounce mode below.
  always_comb begin
    case (cfg_idx_i)
      CFG_LIMIT_MODE, CFG_UPPER_LIMIT, CFG_LOWER_LIMIT,
      CFG_SPRING_GAIN, CFG_DAMPING_GAIN, CFG_MAX_LEVEL: cfg_hit = cfg_we_i;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_OFF;
      upper_q   <= '0;
      lower_q   <= '0;
      spring_q  <= '0;
      damping_q <= '0;
      max_q     <= LEVEL_W'(100);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LIMIT_MODE:   mode_q    <= cfg_data_i[1:0];
        CFG_UPPER_LIMIT:  upper_q   <= cfg_data_i[ANGLE_W-1:0];
        CFG_LOWER_LIMIT:  lower_q   <= cfg_data_i[ANGLE_W-1:0];
        CFG_SPRING_GAIN:  spring_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_DAMPING_GAIN: damping_q <= cfg_data_i[GAIN_W-1:0];
        CFG_MAX_LEVEL:    max_q     <= cfg_data_i[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage 0: limit check, anchor choice, error magnitudes and the settle logic.
  logic                      mode_on, chk_up, chk_lo, hit_up, hit_lo, enter, active;
  logic signed [ANGLE_W-1:0] anchor_use;
  logic signed [ERR_W-1:0]   err;
  logic [ERR_W-1:0]          aerr;
  logic [AVEL_W-1:0]         avel;
  logic                      settled;
  logic [TICK_W-1:0]         ticks_base, ticks_inc;

  always_comb begin
    mode_on = (mode_q == MODE_UPPER) || (mode_q == MODE_BOTH);
    chk_up  = mode_on;
    chk_lo  = (mode_q == MODE_BOTH);
    hit_up  = chk_up && (s0_item_q.knob_angle > upper_q);
    hit_lo  = chk_lo && (s0_item_q.knob_angle < lower_q);
    enter   = !bounce_q && (hit_up || hit_lo);
    active  = mode_on && (bounce_q || enter);

    if (enter) begin
      anchor_use = hit_up ? upper_q : lower_q;
    end else begin
      anchor_use = anchor_q;
    end

    err  = ERR_W'(anchor_use) - ERR_W'(s0_item_q.knob_angle);
    aerr = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    if (s0_item_q.knob_velocity[VEL_W-1]) begin
      avel = AVEL_W'(-AVEL_W'(s0_item_q.knob_velocity));
    end else begin
      avel = AVEL_W'(s0_item_q.knob_velocity);
    end

    settled    = (aerr < ERR_W'(SETTLE_ERR_Q8)) && (avel < AVEL_W'(SETTLE_VEL_LIM));
    ticks_base = enter ? '0 : ticks_q;
    ticks_inc  = (ticks_base == TICK_W'(TICK_MAX)) ? ticks_base : ticks_base + 1'b1;

    bounce_d = bounce_q;
    anchor_d = anchor_q;
    ticks_d  = ticks_q;
    if (cfg_hit) begin
      bounce_d = 1'b0;
      ticks_d  = '0;
    end else if (s0_fire && active) begin
      anchor_d = anchor_use;
      if (settled) begin
        ticks_d  = ticks_inc;
        bounce_d = !(ticks_inc >= TICK_W'(SETTLE_TICKS));
      end else begin
        ticks_d  = '0;
        bounce_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounce_q <= 1'b0;
      ticks_q  <= '0;
    end else begin
      bounce_q <= bounce_d;
      ticks_q  <= ticks_d;
    end
  end

  // The anchor is only read while bouncing, after it has been written.
  always_ff @(posedge clk_i) begin
    anchor_q <= anchor_d;
  end

  // Payload registers of the pipeline.
  always_ff @(posedge clk_i) begin
    if (s0_rdy && in_valid_i) begin
      s0_item_q <= in_item_i;
    end
    if (s0_fire) begin
      s1_eng_q  <= active;
      s1_rev_q  <= !(err > 0);
      s1_aerr_q <= aerr;
      s1_avel_q <= avel;
    end
    if (s1_fire) begin
      s2_eng_q  <= s1_eng_q;
      s2_rev_q  <= s1_rev_q;
      s2_perr_q <= PERR_W'(s1_aerr_q) * PERR_W'(spring_q);
      s2_pvel_q <= PVEL_W'(s1_avel_q) * PVEL_W'(damping_q);
    end
    if (s2_fire) begin
      out_item_q <= out_item_d;
    end
  end

  // Stage 2: spring minus damping, floor, cap and truncation of the fraction.
  logic signed [FORCE_W-1:0]     force_q16;
  logic                          below_floor;
  logic [FORCE_W-FRAC_W-1:0]     lvl;

  always_comb begin
    force_q16   = $signed({1'b0, s2_perr_q}) - $signed(FORCE_W'(s2_pvel_q));
    below_floor = force_q16 < $signed(FORCE_W'(LEVEL_FLOOR) << FRAC_W);
    lvl         = below_floor ? (FORCE_W-FRAC_W)'(LEVEL_FLOOR)
                              : force_q16[FORCE_W-1:FRAC_W];

    out_item_d = '0;
    if (s2_eng_q) begin
      out_item_d.engaged       = 1'b1;
      out_item_d.drive_reverse = s2_rev_q;
      if (lvl > (FORCE_W-FRAC_W)'(max_q)) begin
        out_item_d.drive_level = max_q;
      end else begin
        out_item_d.drive_level = lvl[LEVEL_W-1:0];
      end
    end
  end

endmodule

// ===== tb/haptic_limit_bounce_spring_core_test.sv =====
// Self-checking testbench for the haptic limit bounce spring core (virtual end stop).
// A clocked driver and monitor run against a built-in end-stop predictor.
// Depends on hlbs_pkg and haptic_limit_bounce_spring_core.
module haptic_limit_bounce_spring_core_test;
  import hlbs_pkg::*;

  // Index and mode codes that the package leaves unnamed. Writes to the spare
  // indexes must be ignored, and the spare mode checks no limit at all.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = CFG_IDX_W'(CFG_MAX_LEVEL + 1);
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_IDX   = '1;
  localparam logic [1:0]           MODE_SPARE    = 2'b11;

  localparam longint ANG_MAX = (longint'(1) << (ANGLE_W - 1)) - 1;
  localparam longint ANG_MIN = -(longint'(1) << (ANGLE_W - 1));
  localparam longint VEL_MAX = (longint'(1) << (VEL_W - 1)) - 1;
  localparam longint VEL_MIN = -(longint'(1) << (VEL_W - 1));

  // A result shows up once its item has passed s0, s1, s2 and the output
  // register; wait well past that before touching registers.
  localparam int DRAIN_GAP      = 8;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PAUSE_PCT      = 14;

  logic                  clk_i;
  logic                  rst_ni     = 1'b0;
  logic                  in_valid   = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_item    = '0;
  logic                  out_valid_o;
  logic                  out_stall  = 1'b0;
  out_item_t             out_item_o;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  haptic_limit_bounce_spring_core u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Knob ticks waiting to be driven; the front entry is the one on the bus.
  in_item_t  tick_q[$];
  // Drive commands the end stop is expected to produce, oldest first.
  out_item_t drive_expect_q[$];

  int        n_errors   = 0;
  int        n_taken    = 0;
  int        n_queued   = 0;
  int        quiet_cyc  = 0;
  bit        took_item  = 1'b0;
  out_item_t want;

  // Mirror of the register file and of the bounce state.
  logic [1:0] m_mode    = MODE_OFF;
  longint     m_upper   = 0;
  longint     m_lower   = 0;
  longint     m_kp      = 0;
  longint     m_kd      = 0;
  longint     m_cap     = 100;
  bit         m_bounce  = 1'b0;
  longint     m_anchor  = 0;
  int         m_settle  = 0;

  // Settings of the current random phase, used to aim the stimulus at the limits.
  logic [1:0] cur_mode;
  longint     cur_upper;
  longint     cur_lower;

  // Register write as seen by the block. Any known index drops bounce mode and
  // the settle count; a spare index changes nothing.
  function automatic void latch_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] d);
    bit known;
    known = 1'b1;
    case (cfg_idx_e'(idx))
      CFG_LIMIT_MODE:   m_mode  = d[1:0];
      CFG_UPPER_LIMIT:  m_upper = longint'($signed(d));
      CFG_LOWER_LIMIT:  m_lower = longint'($signed(d));
      CFG_SPRING_GAIN:  m_kp    = longint'(d[GAIN_W-1:0]);
      CFG_DAMPING_GAIN: m_kd    = longint'(d[GAIN_W-1:0]);
      CFG_MAX_LEVEL:    m_cap   = longint'(d[LEVEL_W-1:0]);
      default:          known   = 1'b0;
    endcase
    if (known) begin
      m_bounce = 1'b0;
      m_settle = 0;
    end
  endfunction

  // One control tick of the end stop: entry into bounce mode, the spring and
  // damper level with its floor and cap, the direction, and the settle count.
  function automatic out_item_t end_stop_tick(in_item_t it);
    longint    ang;
    longint    vel;
    longint    avel;
    longint    err;
    longint    aerr;
    longint    lvl_q16;
    out_item_t r;
    r    = '0;
    ang  = longint'($signed(it.knob_angle));
    vel  = longint'($signed(it.knob_velocity));
    avel = (vel < 0) ? -vel : vel;
    if (m_mode == MODE_OFF) return r;
    if (!m_bounce) begin
      if ((m_mode == MODE_UPPER || m_mode == MODE_BOTH) && ang > m_upper) begin
        m_bounce = 1'b1;
        m_anchor = m_upper;
        m_settle = 0;
      end else if (m_mode == MODE_BOTH && ang < m_lower) begin
        m_bounce = 1'b1;
        m_anchor = m_lower;
        m_settle = 0;
      end
    end
    if (!m_bounce) return r;
    err     = m_anchor - ang;
    aerr    = (err < 0) ? -err : err;
    lvl_q16 = aerr * m_kp - avel * m_kd;
    // The floor comes first, so a cap below the floor wins.
    if (lvl_q16 < (longint'(LEVEL_FLOOR) << FRAC_W)) lvl_q16 = longint'(LEVEL_FLOOR) << FRAC_W;
    if (lvl_q16 > (m_cap << FRAC_W)) lvl_q16 = m_cap << FRAC_W;
    r.engaged       = 1'b1;
    r.drive_reverse = (err > 0) ? 1'b0 : 1'b1;
    r.drive_level   = LEVEL_W'(lvl_q16 >>> FRAC_W);
    if (aerr < SETTLE_ERR_Q8 && avel * 10 < 768) begin
      if (m_settle < TICK_MAX) m_settle++;
      if (m_settle >= SETTLE_TICKS) m_bounce = 1'b0;
    end else begin
      m_settle = 0;
    end
    return r;
  endfunction

  // Random idling on both sides, except in one stretch of the run that is
  // kept free of it so the block also sees back-to-back traffic.
  function automatic bit pause_roll();
    if (n_taken >= 450 && n_taken < 650) return 1'b0;
    return $urandom_range(99) < PAUSE_PCT;
  endfunction

  // Accept side: register writes, item accepts with prediction, result checks.
  // Everything here reads values that were set up at the previous falling edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      took_item = 1'b0;
      if (cfg_we) latch_register(cfg_idx, cfg_data);
      if (in_valid && !in_stall_o) begin
        drive_expect_q.push_back(end_stop_tick(in_item));
        void'(tick_q.pop_front());
        n_taken++;
        took_item = 1'b1;
      end
      if (out_valid_o && !out_stall) begin
        if (drive_expect_q.size() == 0) begin
          $display("%0t: result with no item outstanding: engaged %0b reverse %0b level %0d",
                   $time, out_item_o.engaged, out_item_o.drive_reverse,
                   out_item_o.drive_level);
          n_errors++;
        end else begin
          want = drive_expect_q.pop_front();
          if (out_item_o.engaged !== want.engaged) begin
            $display("%0t: engaged mismatch: expected %0b actual %0b",
                     $time, want.engaged, out_item_o.engaged);
            n_errors++;
          end
          if (out_item_o.drive_reverse !== want.drive_reverse) begin
            $display("%0t: drive_reverse mismatch: expected %0b actual %0b",
                     $time, want.drive_reverse, out_item_o.drive_reverse);
            n_errors++;
          end
          if (out_item_o.drive_level !== want.drive_level) begin
            $display("%0t: drive_level mismatch: expected %0d actual %0d",
                     $time, want.drive_level, out_item_o.drive_level);
            n_errors++;
          end
        end
      end
      if (took_item || (out_valid_o && !out_stall)) quiet_cyc = 0;
      else quiet_cyc++;
    end
  end

  // Drive side. A presented item is held until it has been taken; only then
  // may the next one go up or valid drop for an idle cycle.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || took_item) begin
        if (tick_q.size() > 0 && !pause_roll()) begin
          in_valid <= 1'b1;
          in_item  <= tick_q[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= pause_roll();
    end
  end

  // Ends the run if traffic stops for too long, e.g. a lost result.
  initial begin
    while (quiet_cyc < WATCHDOG_LIMIT) @(negedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  function automatic longint span(longint lo, longint hi);
    return lo + longint'($urandom_range(32'(hi - lo)));
  endfunction

  // Narrow registers get random junk above their width now and then; the
  // block must ignore it.
  function automatic logic [CFG_DATA_W-1:0] padded(longint v, int w);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'(v);
    if (w < CFG_DATA_W && $urandom_range(1)) d = d | CFG_DATA_W'($urandom() << w);
    return d;
  endfunction

  function automatic longint pick_gain();
    case ($urandom_range(3))
      0:       return $urandom_range(1) ? 0 : 65535;
      1:       return span(16'h0040, 16'h1000);
      2:       return span(0, 65535);
      default: return span(16'h0100, 16'h0800);
    endcase
  endfunction

  task automatic queue_tick(longint a, longint v);
    in_item_t it;
    if (a > ANG_MAX) a = ANG_MAX;
    if (a < ANG_MIN) a = ANG_MIN;
    it.knob_angle    = ANGLE_W'(a);
    it.knob_velocity = VEL_W'(v);
    tick_q.push_back(it);
    n_queued++;
  endtask

  // Register writes happen one per falling edge; finish_writes drops the
  // enable and returns at a rising edge, where new items may be queued safely.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= d;
  endtask

  task automatic finish_writes();
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits until every queued tick has been taken and every drive command has
  // come back, then lets the pipeline go quiet.
  task automatic drain();
    do @(negedge clk_i); while (tick_q.size() != 0 || drive_expect_q.size() != 0);
    repeat (DRAIN_GAP) @(negedge clk_i);
  endtask

  task automatic program_all(logic [1:0] md, longint up, longint lo, longint kp,
                             longint kd, longint cap);
    if ($urandom_range(3) == 0) write_reg(CFG_SPARE_IDX, CFG_DATA_W'($urandom()));
    write_reg(CFG_UPPER_LIMIT, padded(up, ANGLE_W));
    write_reg(CFG_LOWER_LIMIT, padded(lo, ANGLE_W));
    write_reg(CFG_SPRING_GAIN, padded(kp, GAIN_W));
    write_reg(CFG_DAMPING_GAIN, padded(kd, GAIN_W));
    write_reg(CFG_MAX_LEVEL, padded(cap, LEVEL_W));
    write_reg(CFG_LIMIT_MODE, padded(md, 2));
    finish_writes();
    cur_mode  = md;
    cur_upper = up;
    cur_lower = lo;
  endtask

  // A full end-stop event: the knob overshoots a limit, rings around the
  // anchor, then rests near it, often long enough to release the spring. The
  // resting stretch is broken right at the settle thresholds now and then.
  task automatic bounce_episode();
    bit     use_lower;
    longint anchor;
    longint dir;
    int     n;
    use_lower = (cur_mode == MODE_BOTH) && ($urandom_range(1) == 1);
    anchor    = use_lower ? cur_lower : cur_upper;
    dir       = use_lower ? -1 : 1;
    queue_tick(anchor + dir * span(1, 6000), span(VEL_MIN, VEL_MAX));
    n = $urandom_range(6);
    repeat (n) queue_tick(anchor + span(-12000, 12000), span(-3000, 3000));
    n = $urandom_range(62, 40);
    repeat (n) begin
      if ($urandom_range(29) == 0) begin
        case ($urandom_range(3))
          0:       queue_tick(anchor + SETTLE_ERR_Q8, 0);
          1:       queue_tick(anchor - SETTLE_ERR_Q8, 0);
          2:       queue_tick(anchor, SETTLE_VEL_LIM);
          default: queue_tick(anchor, -SETTLE_VEL_LIM);
        endcase
      end else if ($urandom_range(9) == 0) begin
        queue_tick(anchor + ($urandom_range(1) ? 767 : -767),
                   $urandom_range(1) ? SETTLE_VEL_LIM - 1 : 1 - SETTLE_VEL_LIM);
      end else begin
        queue_tick(anchor + span(-767, 767), span(1 - SETTLE_VEL_LIM, SETTLE_VEL_LIM - 1));
      end
    end
    n = $urandom_range(3);
    repeat (n) queue_tick(anchor - dir * span(0, 2000), span(-200, 200));
  endtask

  task automatic fill_phase(int n);
    int start;
    int k;
    start = n_queued;
    while (n_queued - start < n) begin
      if ((cur_mode == MODE_UPPER || cur_mode == MODE_BOTH) && $urandom_range(9) < 7) begin
        bounce_episode();
      end else begin
        k = $urandom_range(6, 1);
        repeat (k) queue_tick(span(ANG_MIN, ANG_MAX), span(VEL_MIN, VEL_MAX));
      end
    end
  endtask

  // Register settings of one random phase. The first few phases pin the
  // corners: widest error with full gains and the top cap, all-zero gains
  // and cap, the spare and off modes, a cap under the floor, and limits at
  // the ends of the angle range.
  task automatic pick_setting(int p);
    logic [1:0] md;
    longint     up;
    longint     lo;
    longint     kp;
    longint     kd;
    longint     cap;
    int         r;
    r  = $urandom_range(99);
    md = (r < 50) ? MODE_BOTH : (r < 85) ? MODE_UPPER : (r < 93) ? MODE_OFF : MODE_SPARE;
    up = span(0, 40000);
    lo = span(-40000, 0);
    if ($urandom_range(4) == 0) begin
      up = span(ANG_MIN, ANG_MAX);
      lo = span(ANG_MIN, ANG_MAX);
    end
    kp = pick_gain();
    kd = pick_gain();
    case ($urandom_range(5))
      0:       cap = 0;
      1:       cap = 127;
      2:       cap = LEVEL_FLOOR;
      3:       cap = span(0, 127);
      default: cap = 100;
    endcase
    case (p)
      0: begin
        md  = MODE_BOTH;
        up  = ANG_MIN;
        lo  = ANG_MAX;
        kp  = 65535;
        kd  = 65535;
        cap = 127;
      end
      1: begin
        md  = MODE_UPPER;
        up  = 0;
        kp  = 0;
        kd  = 0;
        cap = 0;
      end
      2: md = MODE_SPARE;
      3: md = MODE_OFF;
      4: begin
        md  = MODE_BOTH;
        cap = LEVEL_FLOOR - 1;
      end
      5: begin
        md = MODE_BOTH;
        up = ANG_MAX;
        lo = ANG_MIN + 1;
      end
      default: ;
    endcase
    program_all(md, up, lo, kp, kd, cap);
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Out of reset the end stop is off: even the extreme angles stay free.
    queue_tick(ANG_MAX, VEL_MAX);
    queue_tick(ANG_MIN, VEL_MIN);
    drain();

    // Limits at +/-10 degrees. Overshoot to the top of the range, sit exactly
    // on the anchor (zero error drives in reverse), swing to the bottom.
    program_all(MODE_BOTH, 2560, -2560, 16'h0200, 16'h0100, 100);
    queue_tick(ANG_MAX, VEL_MIN);
    queue_tick(2560, 0);
    queue_tick(ANG_MIN, VEL_MAX);
    queue_tick(2660, 10);
    drain();

    // Writes to spare indexes must leave bounce mode running.
    write_reg(CFG_SPARE_IDX, CFG_DATA_W'($urandom()));
    finish_writes();
    queue_tick(0, 0);
    drain();
    write_reg(CFG_TOP_IDX, CFG_DATA_W'($urandom()));
    finish_writes();
    queue_tick(-100, -50);
    drain();

    // A cap under the floor wins; the write also ends bounce mode, so this
    // tick enters afresh at the lower limit.
    write_reg(CFG_MAX_LEVEL, CFG_DATA_W'(5));
    finish_writes();
    queue_tick(-3560, 0);
    drain();

    // The spare mode checks no limit.
    write_reg(CFG_LIMIT_MODE, CFG_DATA_W'(MODE_SPARE));
    finish_writes();
    queue_tick(ANG_MAX, 0);
    queue_tick(ANG_MIN, 0);
    drain();

    // Upper-only mode ignores the lower limit.
    write_reg(CFG_LIMIT_MODE, CFG_DATA_W'(MODE_UPPER));
    finish_writes();
    queue_tick(ANG_MIN, 0);
    queue_tick(2561, -1);
    drain();

    // A cap above 100 percent is used as written.
    write_reg(CFG_MAX_LEVEL, CFG_DATA_W'(127));
    write_reg(CFG_SPRING_GAIN, CFG_DATA_W'(16'hFFFF));
    finish_writes();
    queue_tick(ANG_MAX, 0);
    drain();

    for (int p = 0; p < 11; p++) begin
      pick_setting(p);
      fill_phase(80);
      drain();
    end

    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/hlbs_pkg.sv
design/haptic_limit_bounce_spring_core.sv
tb/haptic_limit_bounce_spring_core_test.sv
